// ===== rtl/assert_macros.svh =====
// assertion helpers for the parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CNSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("cnsp assertion failed");

// consequent that must hold in the cycle after the antecedent
`define CNSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cnsp assertion failed");

`endif

// ===== rtl/cnsp_pkg.sv =====
`timescale 1ns / 1ps
package cnsp_pkg;

  localparam logic [2:0] PhHeader  = 3'd0;
  localparam logic [2:0] PhName    = 3'd1;
  localparam logic [2:0] PhNamePad = 3'd2;
  localparam logic [2:0] PhData    = 3'd3;
  localparam logic [2:0] PhDataPad = 3'd4;

  localparam logic [2:0] RoleHeader  = 3'd0;
  localparam logic [2:0] RoleName    = 3'd1;
  localparam logic [2:0] RoleNamePad = 3'd2;
  localparam logic [2:0] RoleData    = 3'd3;
  localparam logic [2:0] RoleDataPad = 3'd4;
  localparam logic [2:0] RoleIgnored = 3'd5;

  localparam logic [3:0] StRun        = 4'd0;
  localparam logic [3:0] StTrailer    = 4'd1;
  localparam logic [3:0] StBadMagic   = 4'd2;
  localparam logic [3:0] StBadHex     = 4'd3;
  localparam logic [3:0] StZeroName   = 4'd4;
  localparam logic [3:0] StNamePast   = 4'd5;
  localparam logic [3:0] StNameUnterm = 4'd6;
  localparam logic [3:0] StDataPast   = 4'd7;
  localparam logic [3:0] StEmptyPath  = 4'd8;
  localparam logic [3:0] StNoRoom     = 4'd9;

  localparam logic [1:0] KindOther = 2'd0;
  localparam logic [1:0] KindDir   = 2'd1;
  localparam logic [1:0] KindReg   = 2'd2;

  localparam logic [1:0] PathStrip = 2'd0;
  localparam logic [1:0] PathDot   = 2'd1;
  localparam logic [1:0] PathSlash = 2'd2;
  localparam logic [1:0] PathName  = 2'd3;

  localparam logic [3:0] TrFull  = 4'd10;
  localparam logic [3:0] TrEnded = 4'd11;
  localparam logic [3:0] TrNul   = 4'd12;
  localparam logic [3:0] TrMiss  = 4'd15;

  localparam logic [3:0] FldMode  = 4'd1;
  localparam logic [3:0] FldUid   = 4'd2;
  localparam logic [3:0] FldGid   = 4'd3;
  localparam logic [3:0] FldSize  = 4'd6;
  localparam logic [3:0] FldNameL = 4'd11;

  localparam logic [6:0] HdrLen   = 7'd110;
  localparam logic [6:0] HdrLast  = 7'd109;
  localparam logic [6:0] MagicLen = 7'd6;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChSlash = 8'h2f;

  typedef struct packed {
    logic [2:0]  phase;
    logic [6:0]  hdr_pos;
    logic [31:0] hex_acc;
    logic [31:0] mode;
    logic [31:0] uid;
    logic [31:0] gid;
    logic [31:0] size;
    logic [31:0] name_len;
    logic [31:0] remaining;
    logic [3:0]  trailer;
    logic [1:0]  path;
    logic [31:0] count;
    logic [3:0]  status;
  } cnsp_state_t;

  typedef struct packed {
    logic [2:0]  role;
    logic [7:0]  value;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] mode;
    logic [31:0] uid;
    logic [31:0] gid;
    logic [31:0] size;
    logic        last;
    logic [31:0] count;
    logic [3:0]  status;
  } cnsp_res_t;

  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h30;
      3'd1:    c = 8'h37;
      3'd2:    c = 8'h30;
      3'd3:    c = 8'h37;
      3'd4:    c = 8'h30;
      3'd5:    c = 8'h31;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] trailer_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h54;
      4'd1:    c = 8'h52;
      4'd2:    c = 8'h41;
      4'd3:    c = 8'h49;
      4'd4:    c = 8'h4c;
      4'd5:    c = 8'h45;
      4'd6:    c = 8'h52;
      4'd7:    c = 8'h21;
      4'd8:    c = 8'h21;
      4'd9:    c = 8'h21;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // bit 4 set means not a hex digit
  function automatic logic [4:0] nibble_of(input logic [7:0] b);
    logic [4:0] n;
    case (b) inside
      [8'h30:8'h39]: n = 5'(b - 8'h30);
      [8'h61:8'h66]: n = 5'(b - 8'h57);
      [8'h41:8'h46]: n = 5'(b - 8'h37);
      default:       n = 5'h10;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] kind_of(input logic [31:0] mode);
    logic [1:0] k;
    case (mode[15:12])
      4'o04:   k = KindDir;
      4'o10:   k = KindReg;
      default: k = KindOther;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/cnsp_in_if.sv =====
`timescale 1ns / 1ps
interface cnsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// ===== rtl/cnsp_out_if.sv =====
`timescale 1ns / 1ps
interface cnsp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_role;
  logic [7:0]  byte_value;
  logic        entry_ready;
  logic [1:0]  entry_kind;
  logic [31:0] entry_mode;
  logic [31:0] entry_uid;
  logic [31:0] entry_gid;
  logic [31:0] entry_file_size;
  logic        last_data;
  logic [31:0] entries_counted;
  logic [3:0]  status;

  modport source (
    output valid, output byte_role, output byte_value, output entry_ready,
    output entry_kind, output entry_mode, output entry_uid, output entry_gid,
    output entry_file_size, output last_data, output entries_counted,
    output status, input ready
  );
  modport sink (
    input valid, input byte_role, input byte_value, input entry_ready,
    input entry_kind, input entry_mode, input entry_uid, input entry_gid,
    input entry_file_size, input last_data, input entries_counted,
    input status, output ready
  );
endinterface

// ===== rtl/cnsp_step.sv =====
`timescale 1ns / 1ps
module cnsp_step import cnsp_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  cnsp_state_t            st_i,
  input  logic [OFFSET_BITS-1:0] offset_i,
  input  logic [7:0]             byte_i,
  input  logic [31:0]            archive_size_i,
  output cnsp_state_t            st_o,
  output logic [OFFSET_BITS-1:0] offset_o,
  output cnsp_res_t              res_o
);

  localparam int SumW = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 2;

  logic [SumW-1:0] off_w, end_w, al_w, arch_w;
  logic            room_off_bad, room_end_bad, name_past, data_past;
  logic [1:0]      pad;
  logic [3:0]      fld;
  logic [2:0]      dig;
  logic [6:0]      rel;
  logic [4:0]      nib;

  assign off_w        = SumW'(offset_i);
  assign end_w        = off_w + SumW'(1);
  assign al_w         = (end_w + SumW'(3)) & ~SumW'(3);
  assign arch_w       = SumW'(archive_size_i);
  assign room_off_bad = (off_w + SumW'(HdrLen)) > arch_w;
  assign room_end_bad = (end_w + SumW'(HdrLen)) > arch_w;
  assign name_past    = (end_w + SumW'(st_i.name_len)) > arch_w;
  assign data_past    = (al_w > arch_w) || ((al_w + SumW'(st_i.size)) > arch_w);
  assign pad          = 2'd0 - end_w[1:0];
  assign rel          = st_i.hdr_pos - MagicLen;
  assign fld          = rel[6:3];
  assign dig          = rel[2:0];
  assign nib          = nibble_of(byte_i);

  always_comb begin
    cnsp_state_t nx;
    logic [2:0]  role;
    logic        ready;
    logic        last;
    logic        finish;
    logic        data_pad;
    logic        entry_end;
    logic        hex_fld;
    logic [31:0] acc;
    logic [3:0]  tm;
    logic [1:0]  ps;

    nx        = st_i;
    role      = RoleIgnored;
    ready     = 1'b0;
    last      = 1'b0;
    finish    = 1'b0;
    data_pad  = 1'b0;
    entry_end = 1'b0;
    hex_fld   = 1'b0;
    acc       = st_i.hex_acc;
    tm        = st_i.trailer;
    ps        = st_i.path;
    offset_o  = offset_i;

    if (st_i.status == StRun) begin
      offset_o = end_w[OFFSET_BITS-1:0];
      case (st_i.phase)
        PhHeader: begin
          if (st_i.hdr_pos == '0 && room_off_bad) begin
            nx.status = StNoRoom;
          end else begin
            role = RoleHeader;
            if (st_i.hdr_pos < MagicLen) begin
              if (byte_i != magic_char(st_i.hdr_pos[2:0])) nx.status = StBadMagic;
            end else begin
              case (fld)
                FldMode, FldUid, FldGid, FldSize, FldNameL: hex_fld = 1'b1;
                default: hex_fld = 1'b0;
              endcase
              if (hex_fld) begin
                if (nib[4]) begin
                  nx.status = StBadHex;
                end else begin
                  acc = (dig == 3'd0) ? {28'd0, nib[3:0]} : {st_i.hex_acc[27:0], nib[3:0]};
                  nx.hex_acc = acc;
                  if (dig == 3'd7) begin
                    case (fld)
                      FldMode:  nx.mode = acc;
                      FldUid:   nx.uid = acc;
                      FldGid:   nx.gid = acc;
                      FldSize:  nx.size = acc;
                      default:  nx.name_len = acc;
                    endcase
                  end
                end
              end
            end
            if (nx.status == StRun) begin
              if (st_i.hdr_pos >= HdrLast) begin
                if (st_i.name_len == '0) begin
                  nx.status = StZeroName;
                end else if (name_past) begin
                  nx.status = StNamePast;
                end else begin
                  nx.phase     = PhName;
                  nx.remaining = st_i.name_len;
                  nx.trailer   = '0;
                  nx.path      = PathStrip;
                  nx.hdr_pos   = '0;
                end
              end else begin
                nx.hdr_pos = st_i.hdr_pos + 7'd1;
              end
            end
          end
        end
        PhName: begin
          role = RoleName;
          if (!(st_i.trailer == TrEnded || st_i.trailer == TrNul)) begin
            case (st_i.path)
              PathStrip: ps = (byte_i == ChDot) ? PathDot : (byte_i == ChSlash) ? PathSlash :
                              (byte_i == ChNul) ? PathStrip : PathName;
              PathDot:   ps = (byte_i == ChSlash) ? PathStrip : PathName;
              PathSlash: ps = (byte_i == ChSlash || byte_i == ChNul) ? PathSlash : PathName;
              default:   ps = st_i.path;
            endcase
            if (st_i.trailer < TrFull) begin
              tm = (byte_i == trailer_char(st_i.trailer)) ? st_i.trailer + 4'd1 :
                   (byte_i == ChNul) ? TrNul : TrMiss;
            end else if (st_i.trailer == TrFull) begin
              tm = (byte_i == ChNul) ? TrEnded : TrMiss;
            end else begin
              tm = (byte_i == ChNul) ? TrNul : TrMiss;
            end
            nx.path    = ps;
            nx.trailer = tm;
          end
          if (st_i.remaining > 32'd1) begin
            nx.remaining = st_i.remaining - 32'd1;
          end else begin
            nx.remaining = '0;
            if (byte_i != ChNul) nx.status = StNameUnterm;
            else if (data_past) nx.status = StDataPast;
            else if (tm == TrEnded) nx.status = StTrailer;
            else if (ps == PathStrip || ps == PathSlash) nx.status = StEmptyPath;
            else if (pad != 2'd0) begin
              nx.phase     = PhNamePad;
              nx.remaining = {30'd0, pad};
            end else begin
              finish = 1'b1;
            end
          end
        end
        PhNamePad: begin
          role = RoleNamePad;
          if (st_i.remaining > 32'd1) nx.remaining = st_i.remaining - 32'd1;
          else begin
            nx.remaining = '0;
            finish       = 1'b1;
          end
        end
        PhData: begin
          role = RoleData;
          if (st_i.remaining > 32'd1) nx.remaining = st_i.remaining - 32'd1;
          else begin
            nx.remaining = '0;
            last         = 1'b1;
            data_pad     = 1'b1;
          end
        end
        PhDataPad: begin
          role = RoleDataPad;
          if (st_i.remaining > 32'd1) nx.remaining = st_i.remaining - 32'd1;
          else begin
            nx.remaining = '0;
            entry_end    = 1'b1;
          end
        end
        default: begin
          nx.phase   = PhHeader;
          nx.hdr_pos = '0;
        end
      endcase

      if (finish) begin
        ready = 1'b1;
        if (kind_of(st_i.mode) != KindOther) nx.count = st_i.count + 32'd1;
        if (st_i.size != '0) begin
          nx.phase     = PhData;
          nx.remaining = st_i.size;
        end else begin
          data_pad = 1'b1;
        end
      end
      if (data_pad) begin
        if (pad != 2'd0) begin
          nx.phase     = PhDataPad;
          nx.remaining = {30'd0, pad};
        end else begin
          entry_end = 1'b1;
        end
      end
      if (entry_end) begin
        nx.phase   = PhHeader;
        nx.hdr_pos = '0;
        if (room_end_bad) nx.status = StNoRoom;
      end
    end

    st_o         = nx;
    res_o.role   = role;
    res_o.value  = byte_i;
    res_o.ready  = ready;
    res_o.kind   = kind_of(nx.mode);
    res_o.mode   = nx.mode;
    res_o.uid    = nx.uid;
    res_o.gid    = nx.gid;
    res_o.size   = nx.size;
    res_o.last   = last;
    res_o.count  = nx.count;
    res_o.status = nx.status;
  end

endmodule

// ===== rtl/cpio_newc_stream_parser_core.sv =====
`timescale 1ns / 1ps
// channel   dir  payload                                         handshake
// in_i      in   data_byte                                       valid/ready
// out_o     out  byte_role .. status (one result per byte)       valid/ready
// cfg       in   cfg_wdata_i = archive_size                      cfg_we_i
//
// one byte per cycle sustained while the output is not stalled
// the input register and the result register each hold one byte, the parse step
// between them is a single pass of combinational logic
// reset clears the parser state, the offset, archive_size and both valid flags
// a stalled output holds its result and the input side fills one byte then waits
`include "assert_macros.svh"
module cpio_newc_stream_parser_core import cnsp_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  cnsp_in_if.sink           in_i,
  cnsp_out_if.source        out_o
);

  logic [31:0]            arch_q;
  logic                   s1_valid_q;
  logic [7:0]             s1_byte_q;
  logic                   out_valid_q;
  cnsp_res_t              out_res_q;
  cnsp_res_t              res_d;
  cnsp_state_t            st_q, st_d;
  logic [OFFSET_BITS-1:0] offset_q, offset_d;
  logic                   advance;

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  cnsp_step #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_step (
    .st_i          (st_q),
    .offset_i      (offset_q),
    .byte_i        (s1_byte_q),
    .archive_size_i(arch_q),
    .st_o          (st_d),
    .offset_o      (offset_d),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arch_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
      offset_q    <= '0;
    end else begin
      if (cfg_we_i) arch_q <= cfg_wdata_i;
      if (in_i.valid && in_i.ready) s1_valid_q <= 1'b1;
      else if (advance) s1_valid_q <= 1'b0;
      if (advance) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
        offset_q    <= offset_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) s1_byte_q <= in_i.data_byte;
    if (advance) out_res_q <= res_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.byte_role       = out_res_q.role;
  assign out_o.byte_value      = out_res_q.value;
  assign out_o.entry_ready     = out_res_q.ready;
  assign out_o.entry_kind      = out_res_q.kind;
  assign out_o.entry_mode      = out_res_q.mode;
  assign out_o.entry_uid       = out_res_q.uid;
  assign out_o.entry_gid       = out_res_q.gid;
  assign out_o.entry_file_size = out_res_q.size;
  assign out_o.last_data       = out_res_q.last;
  assign out_o.entries_counted = out_res_q.count;
  assign out_o.status          = out_res_q.status;

  `CNSP_ASSERT_NEXT(a_status_sticky, st_q.status != StRun, st_q.status == $past(st_q.status))
  `CNSP_ASSERT_NEXT(a_offset_frozen, st_q.status != StRun, $stable(offset_q))
  `CNSP_ASSERT(a_ready_on_name, !(out_valid_q && out_res_q.ready) || out_res_q.role == RoleName || out_res_q.role == RoleNamePad)
  `CNSP_ASSERT(a_last_on_data, !(out_valid_q && out_res_q.last) || out_res_q.role == RoleData)

endmodule

// ===== dv/cpio_newc_stream_parser_core_tb.sv =====
`timescale 1ns / 1ps
import cnsp_pkg::*;

localparam logic [47:0] MagicText   = "070701";
localparam logic [79:0] TrailerText = "TRAILER!!!";
localparam logic [3:0]  TypeDir     = 4'b0100;
localparam logic [3:0]  TypeReg     = 4'b1000;

class newc_scoreboard;
  logic [63:0] size_limit;
  logic [31:0] offset;
  logic [2:0]  phase;
  logic [6:0]  hdr_idx;
  logic [31:0] acc;
  logic [31:0] mode;
  logic [31:0] uid;
  logic [31:0] gid;
  logic [31:0] fsize;
  logic [31:0] nlen;
  logic [31:0] left;
  logic [31:0] count;
  logic [3:0]  trail;
  logic [3:0]  status;
  logic [1:0]  path;
  logic        ready_now;
  cnsp_res_t   pending_results[$];
  int          mismatches;

  function new();
    size_limit = '0;
    offset     = '0;
    phase      = PhHeader;
    hdr_idx    = '0;
    acc        = '0;
    mode       = '0;
    uid        = '0;
    gid        = '0;
    fsize      = '0;
    nlen       = '0;
    left       = '0;
    count      = '0;
    trail      = '0;
    status     = StRun;
    path       = PathStrip;
    ready_now  = 1'b0;
    mismatches = 0;
  endfunction

  function logic [63:0] up4(logic [63:0] v);
    return (v + 64'd3) & ~64'd3;
  endfunction

  function logic [1:0] type_of(logic [31:0] m);
    case (m[15:12])
      TypeDir: return KindDir;
      TypeReg: return KindReg;
      default: return KindOther;
    endcase
  endfunction

  function logic [4:0] digit_of(logic [7:0] b);
    if (b >= "0" && b <= "9") return 5'(b - "0");
    if (b >= "a" && b <= "f") return 5'(b - "a" + 10);
    if (b >= "A" && b <= "F") return 5'(b - "A" + 10);
    return 5'h10;
  endfunction

  function void close_entry(logic [63:0] e);
    phase   = PhHeader;
    hdr_idx = '0;
    if (e + HdrLen > size_limit) status = StNoRoom;
  endfunction

  function void after_data(logic [63:0] e);
    logic [63:0] pad;
    pad = up4(e) - e;
    if (pad != 0) begin
      phase = PhDataPad;
      left  = pad[31:0];
    end else begin
      close_entry(e);
    end
  endfunction

  function void name_done(logic [63:0] e);
    ready_now = 1'b1;
    if (type_of(mode) != KindOther) count++;
    if (fsize != 0) begin
      phase = PhData;
      left  = fsize;
    end else begin
      after_data(e);
    end
  endfunction

  function void header_in(logic [7:0] b, logic [63:0] e);
    int unsigned rel;
    int unsigned fld;
    int unsigned dig;
    logic [4:0]  n;
    if (hdr_idx < MagicLen) begin
      if (b != MagicText[47 - 8 * hdr_idx -: 8]) begin
        status = StBadMagic;
        return;
      end
    end else begin
      rel = 32'(hdr_idx - MagicLen);
      fld = rel >> 3;
      dig = rel & 7;
      if (fld == FldMode || fld == FldUid || fld == FldGid || fld == FldSize ||
          fld == FldNameL) begin
        n = digit_of(b);
        if (n[4]) begin
          status = StBadHex;
          return;
        end
        acc = (dig == 0) ? {28'd0, n[3:0]} : {acc[27:0], n[3:0]};
        if (dig == 7) begin
          if (fld == FldMode) mode = acc;
          else if (fld == FldUid) uid = acc;
          else if (fld == FldGid) gid = acc;
          else if (fld == FldSize) fsize = acc;
          else nlen = acc;
        end
      end
    end
    if (hdr_idx >= HdrLast) begin
      if (nlen == 0) begin
        status = StZeroName;
        return;
      end
      if (e + nlen > size_limit) begin
        status = StNamePast;
        return;
      end
      phase   = PhName;
      left    = nlen;
      trail   = '0;
      path    = PathStrip;
      hdr_idx = '0;
    end else begin
      hdr_idx = hdr_idx + 7'd1;
    end
  endfunction

  function void name_in(logic [7:0] b, logic [63:0] e);
    logic [3:0]  tm;
    logic [1:0]  ps;
    logic [63:0] al;
    tm = trail;
    ps = path;
    if (!(tm == TrEnded || tm == TrNul)) begin
      case (ps)
        PathStrip: ps = (b == ChDot) ? PathDot : (b == ChSlash) ? PathSlash :
                        (b == ChNul) ? PathStrip : PathName;
        PathDot:   ps = (b == ChSlash) ? PathStrip : PathName;
        PathSlash: ps = (b == ChSlash || b == ChNul) ? PathSlash : PathName;
        default:   ps = PathName;
      endcase
      if (tm < TrFull) begin
        tm = (b == TrailerText[79 - 8 * tm -: 8]) ? tm + 4'd1 :
             (b == ChNul) ? TrNul : TrMiss;
      end else if (tm == TrFull) begin
        tm = (b == ChNul) ? TrEnded : TrMiss;
      end else begin
        tm = (b == ChNul) ? TrNul : TrMiss;
      end
      path  = ps;
      trail = tm;
    end
    if (left > 1) begin
      left--;
      return;
    end
    left = '0;
    if (b != ChNul) begin
      status = StNameUnterm;
      return;
    end
    al = up4(e);
    if (al > size_limit || al + fsize > size_limit) begin
      status = StDataPast;
      return;
    end
    if (tm == TrEnded) begin
      status = StTrailer;
      return;
    end
    if (ps == PathStrip || ps == PathSlash) begin
      status = StEmptyPath;
      return;
    end
    if (al != e) begin
      phase = PhNamePad;
      left  = 32'(al - e);
    end else begin
      name_done(e);
    end
  endfunction

  // one accepted archive byte in, one predicted result queued
  function void note_byte(logic [7:0] b);
    cnsp_res_t   r;
    logic [63:0] e;
    r         = '0;
    r.role    = RoleIgnored;
    ready_now = 1'b0;
    if (status == StRun) begin
      e = {32'd0, offset} + 64'd1;
      case (phase)
        PhHeader: begin
          if (hdr_idx == 0 && {32'd0, offset} + HdrLen > size_limit) begin
            status = StNoRoom;
          end else begin
            r.role = RoleHeader;
            header_in(b, e);
          end
        end
        PhName: begin
          r.role = RoleName;
          name_in(b, e);
        end
        PhNamePad: begin
          r.role = RoleNamePad;
          if (left > 1) begin
            left--;
          end else begin
            left = '0;
            name_done(e);
          end
        end
        PhData: begin
          r.role = RoleData;
          if (left > 1) begin
            left--;
          end else begin
            left   = '0;
            r.last = 1'b1;
            after_data(e);
          end
        end
        PhDataPad: begin
          r.role = RoleDataPad;
          if (left > 1) begin
            left--;
          end else begin
            left = '0;
            close_entry(e);
          end
        end
        default: begin
          phase   = PhHeader;
          hdr_idx = '0;
        end
      endcase
      offset = e[31:0];
    end
    r.value  = b;
    r.ready  = ready_now;
    r.kind   = type_of(mode);
    r.mode   = mode;
    r.uid    = uid;
    r.gid    = gid;
    r.size   = fsize;
    r.count  = count;
    r.status = status;
    pending_results.push_back(r);
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch %s: got %0h want %0h", $time, what, got, want);
  endtask

  task cmp(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report(what, got, want);
  endtask

  task check_result(cnsp_res_t got);
    cnsp_res_t want;
    if (pending_results.size() == 0) begin
      report("result with nothing pending, byte_value", 32'(got.value), '0);
      return;
    end
    want = pending_results.pop_front();
    cmp("byte_role", 32'(got.role), 32'(want.role));
    cmp("byte_value", 32'(got.value), 32'(want.value));
    cmp("entry_ready", 32'(got.ready), 32'(want.ready));
    cmp("entry_kind", 32'(got.kind), 32'(want.kind));
    cmp("entry_mode", got.mode, want.mode);
    cmp("entry_uid", got.uid, want.uid);
    cmp("entry_gid", got.gid, want.gid);
    cmp("entry_file_size", got.size, want.size);
    cmp("last_data", 32'(got.last), 32'(want.last));
    cmp("entries_counted", got.count, want.count);
    cmp("status", 32'(got.status), 32'(want.status));
  endtask
endclass

module cpio_newc_stream_parser_core_tb;
  typedef enum logic [3:0] {
    FinTrailer, FinBadMagic, FinBadHex, FinZeroName, FinNamePast,
    FinUnterm, FinDataPast, FinEmptyPath, FinNoRoomHdr, FinNoRoomEntry
  } fin_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  cnsp_in_if  byte_if ();
  cnsp_out_if res_if ();

  cpio_newc_stream_parser_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (byte_if),
    .out_o       (res_if)
  );

  newc_scoreboard sb = new();
  int unsigned    send_idle_pct;
  int unsigned    recv_stall_pct;
  byte unsigned   arch_bytes[$];
  byte unsigned   name_q[$];
  logic [63:0]    arch_pos;
  cnsp_res_t      seen;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("cpio_newc_stream_parser_core_tb NOT OK");
    $finish;
  end

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen.role   = res_if.byte_role;
      seen.value  = res_if.byte_value;
      seen.ready  = res_if.entry_ready;
      seen.kind   = res_if.entry_kind;
      seen.mode   = res_if.entry_mode;
      seen.uid    = res_if.entry_uid;
      seen.gid    = res_if.entry_gid;
      seen.size   = res_if.entry_file_size;
      seen.last   = res_if.last_data;
      seen.count  = res_if.entries_counted;
      seen.status = res_if.status;
      sb.check_result(seen);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    do @(posedge clk_i); while (!byte_if.ready);
    sb.note_byte(b);
  endtask

  task automatic stream_out();
    while (arch_bytes.size() > 0) send_byte(arch_bytes.pop_front());
    byte_if.valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    sb.size_limit  = {32'd0, v};
  endtask

  function automatic void put_byte(input logic [7:0] b);
    arch_bytes.push_back(b);
    arch_pos++;
  endfunction

  function automatic void put_hex(input logic [31:0] v);
    logic [3:0] nib;
    for (int i = 7; i >= 0; i--) begin
      nib = v[i*4 +: 4];
      if (nib < 10) put_byte(8'h30 + nib);
      else put_byte(($urandom_range(1) ? 8'h41 : 8'h61) + nib - 8'd10);
    end
  endfunction

  // unchecked fields get arbitrary bytes
  function automatic void put_header(input logic [31:0] mode, input logic [31:0] uid,
                                     input logic [31:0] gid, input logic [31:0] fsize,
                                     input logic [31:0] nlen);
    for (int i = 0; i < MagicLen; i++) put_byte(MagicText[47 - 8 * i -: 8]);
    for (int f = 0; f < 13; f++) begin
      if (f == FldMode) put_hex(mode);
      else if (f == FldUid) put_hex(uid);
      else if (f == FldGid) put_hex(gid);
      else if (f == FldSize) put_hex(fsize);
      else if (f == FldNameL) put_hex(nlen);
      else repeat (8) put_byte(8'($urandom_range(255)));
    end
  endfunction

  function automatic void add_entry(input logic [31:0] mode, input logic [31:0] uid,
                                    input logic [31:0] gid, input int unsigned fsize);
    put_header(mode, uid, gid, fsize, name_q.size());
    foreach (name_q[i]) put_byte(name_q[i]);
    while (arch_pos[1:0] != 2'd0) put_byte(8'($urandom_range(255)));
    repeat (fsize) put_byte(8'($urandom_range(255)));
    while (arch_pos[1:0] != 2'd0) put_byte(8'($urandom_range(255)));
  endfunction

  function automatic void name_from(input string s);
    name_q = {};
    for (int i = 0; i < s.len(); i++) name_q.push_back(s[i]);
    name_q.push_back(ChNul);
  endfunction

  // optional leading dot and slash parts, then at least one real character
  function automatic void make_random_name();
    logic [7:0] c;
    case ($urandom_range(4))
      0: name_from("");
      1: name_from("./");
      2: name_from("/");
      3: name_from("//");
      default: name_from("././");
    endcase
    void'(name_q.pop_back());
    do c = 8'($urandom_range(1, 255)); while (c == ChDot || c == ChSlash);
    name_q.push_back(c);
    repeat ($urandom_range(8)) name_q.push_back(8'($urandom_range(255)));
    name_q.push_back(ChNul);
  endfunction

  function automatic logic [31:0] pick_mode();
    logic [3:0] t;
    case ($urandom_range(2))
      0: t = TypeDir;
      1: t = TypeReg;
      default: t = 4'($urandom);
    endcase
    return {16'($urandom), t, 12'($urandom)};
  endfunction

  function automatic logic [31:0] pick_id();
    case ($urandom_range(3))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_size();
    return ($urandom_range(9) == 0) ? $urandom_range(17, 48) : $urandom_range(16);
  endfunction

  function automatic void random_entry();
    make_random_name();
    add_entry(pick_mode(), pick_id(), pick_id(), pick_size());
  endfunction

  initial begin
    fin_t          fin;
    logic [31:0]   span;
    logic [63:0]   start;
    logic [7:0]    b;
    int unsigned   spot;
    int unsigned   fsize;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    arch_pos          = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_size(32'h0);
    @(posedge clk_i);
    write_size(32'hFFFF_FFFF);
    // directory, regular with a near-trailer name, other type with an embedded nul
    name_from("./d");
    add_entry(32'h0000_41ED, 32'h0, 32'hFFFF_FFFF, 0);
    name_from("TRAILER!!!x");
    add_entry(32'hFFFF_81A4, 32'hFFFF_FFFF, 32'h0, 5);
    name_from("//a");
    name_q.push_back(8'h62);
    name_q.push_back(ChNul);
    add_entry(32'h0000_A1FF, 32'h1234_ABCD, 32'h0, 4);
    stream_out();
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 63 : (ph == 3) ? 28 : 0;
      recv_stall_pct = (ph == 2) ? 63 : (ph == 3) ? 28 : 0;
      if (ph == 1) write_size(32'hFFFF_FFFF);
      else write_size(32'(arch_pos + 5000 + $urandom_range(100000)));
      repeat (1) random_entry();
      stream_out();
      drain();
    end

    // one way of ending the archive, then bytes that must be ignored
    spot           = $urandom_range(3);
    send_idle_pct  = (spot == 1) ? 63 : (spot == 3) ? 28 : 0;
    recv_stall_pct = (spot == 2) ? 63 : (spot == 3) ? 28 : 0;
    start          = arch_pos;
    span           = 32'hFFFF_FFFF;
    fin            = fin_t'($urandom_range(FinNoRoomEntry));
    case (fin)
      FinTrailer: begin
        name_from("TRAILER!!!");
        add_entry(pick_mode(), pick_id(), pick_id(), $urandom_range(3));
      end
      FinBadMagic: begin
        random_entry();
        spot = $urandom_range(MagicLen - 1);
        arch_bytes[spot] = arch_bytes[spot] ^ 8'($urandom_range(1, 255));
      end
      FinBadHex: begin
        random_entry();
        case ($urandom_range(4))
          0: spot = FldMode;
          1: spot = FldUid;
          2: spot = FldGid;
          3: spot = FldSize;
          default: spot = FldNameL;
        endcase
        spot = MagicLen + 8 * spot + $urandom_range(7);
        do b = 8'($urandom_range(255)); while (sb.digit_of(b) < 16);
        arch_bytes[spot] = b;
      end
      FinZeroName: begin
        put_header(pick_mode(), pick_id(), pick_id(), pick_size(), 0);
      end
      FinNamePast: begin
        make_random_name();
        span = 32'(start + HdrLen + name_q.size() - 1);
        add_entry(pick_mode(), pick_id(), pick_id(), pick_size());
      end
      FinUnterm: begin
        make_random_name();
        name_q[name_q.size() - 1] = 8'($urandom_range(1, 255));
        add_entry(pick_mode(), pick_id(), pick_id(), pick_size());
      end
      FinDataPast: begin
        make_random_name();
        fsize = $urandom_range(1, 16);
        span  = 32'(sb.up4(start + HdrLen + name_q.size()) + fsize - 1);
        add_entry(pick_mode(), pick_id(), pick_id(), fsize);
      end
      FinEmptyPath: begin
        case ($urandom_range(3))
          0: name_from("");
          1: name_from("./");
          2: name_from("//");
          default: begin
            name_from("./");
            name_q.push_back(8'h78);
            name_q.push_back(ChNul);
          end
        endcase
        add_entry(pick_mode(), pick_id(), pick_id(), pick_size());
      end
      FinNoRoomHdr: begin
        span = $urandom_range(1) ? 32'h0 : 32'(start + $urandom_range(HdrLast));
      end
      default: begin
        random_entry();
        span = 32'(arch_pos + $urandom_range(HdrLast));
      end
    endcase
    repeat (40) put_byte(8'($urandom_range(255)));
    write_size(span);
    stream_out();
    drain();
    repeat (8) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("cpio_newc_stream_parser_core_tb OK");
    end else begin
      $display("cpio_newc_stream_parser_core_tb NOT OK");
    end
    $finish;
  end
endmodule
